/* rtl/ndk_pkg.sv */
package ndk_pkg;

  localparam int CMD_W          = 2;
  localparam int COORD_W        = 16;
  localparam int DIST_W         = 42;
  localparam int RANK_W         = 4;
  localparam int CFG_W          = 5;
  localparam int DEF_MAX_DIM    = 1024;
  localparam int DEF_MAX_KEPT   = 16;
  localparam int DEF_COORD_BITS = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY = 2'd0,
    CMD_POINT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_POINT = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] coord;
    logic               last;
  } qentry_t;

endpackage

/* rtl/ndk_if.sv */
interface ndk_in_if import ndk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COORD_W-1:0] coordinate;
  logic               last_coordinate;

  modport source (output valid, output cmd, output coordinate, output last_coordinate,
                  input ready);
  modport sink (input valid, input cmd, input coordinate, input last_coordinate,
                output ready);
endinterface

interface ndk_out_if import ndk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_sq;
  logic [RANK_W-1:0] rank;
  logic              set_empty;
  logic              last_result;

  modport source (output valid, output distance_sq, output rank, output set_empty,
                  output last_result, input ready);
  modport sink (input valid, input distance_sq, input rank, input set_empty,
                input last_result, output ready);
endinterface

/* rtl/nearest_distance_keeper_unit.sv */
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   cmd, coordinate, last_coordinate
// out_ch    out  valid / ready   distance_sq, rank, set_empty, last_result
// cfg       in   cfg_we          cfg_wdata (nearest_count)
//
// Transactions enter a 4-entry queue; the back end runs one at a time.
// Query coordinate: written to query memory. Point coordinate: memory read, subtract, square,
// accumulate, plus compare and insert on the last; before the query is complete, EXEC only.
// Readout: one result per out_ch transfer, held while out_ch stalls.
// Reset: synchronous, active low; query memory and kept list hold no reset.
module nearest_distance_keeper_unit import ndk_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_KEPT   = DEF_MAX_KEPT,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  ndk_in_if.sink           in_ch,
  ndk_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic    q_full, q_push, q_pop, q_empty;
  qentry_t q_data, q_head;

  ndk_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  ndk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ndk_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.set_empty |-> out_ch.last_result && out_ch.rank == '0)
    else $error("empty readout result not final or not rank 0");

  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_result |=>
      !out_ch.valid || out_ch.rank == $past(out_ch.rank) + 1'b1)
    else $error("readout rank does not advance by one");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_result |=>
      !out_ch.valid || out_ch.distance_sq > $past(out_ch.distance_sq))
    else $error("readout distances not strictly ascending");

endmodule

/* rtl/ndk_front.sv */
module ndk_front import ndk_pkg::*; (
  ndk_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     q_push,
  output qentry_t  q_data
);

  logic cmd_known;

  assign in_ch.ready = !q_full;

  always_comb begin
    cmd_known     = 1'b1;
    q_data.op     = OP_QUERY;
    q_data.coord  = in_ch.coordinate;
    q_data.last   = in_ch.last_coordinate;
    unique case (cmd_t'(in_ch.cmd))
      CMD_QUERY: q_data.op = OP_QUERY;
      CMD_POINT: q_data.op = OP_POINT;
      CMD_READ:  q_data.op = OP_READ;
      default:   cmd_known = 1'b0;
    endcase
  end

  // drop unknown commands after accepting them
  assign q_push = in_ch.valid && in_ch.ready && cmd_known;

endmodule

/* rtl/ndk_queue.sv */
module ndk_queue import ndk_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output qentry_t head,
  output logic    empty
);

  qentry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/ndk_back.sv */
module ndk_back import ndk_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int MAX_KEPT   = DEF_MAX_KEPT,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             q_empty,
  input  qentry_t          q_head,
  output logic             q_pop,
  ndk_out_if.source        out_ch
);

  localparam int LEN_W  = $clog2(MAX_DIM + 2);
  localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int KC_W   = $clog2(MAX_KEPT + 1);
  localparam int KI_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_INS  = 8'b0100_0000,
    S_READ = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  qentry_t                       cur_r;
  logic [CFG_W-1:0]              cfg_r;
  logic signed [COORD_BITS-1:0]  qmem [MAX_DIM];
  logic signed [COORD_BITS-1:0]  rd_data_r;
  logic [LEN_W-1:0]              qlen_r, pos_r, eff_len, pos_inc;
  logic [DIST_W-1:0]             acc_r, acc_add, offer_r;
  logic [DIST_W:0]               acc_sum;
  logic                          done_r;
  logic [DIST_W-1:0]             kept_r   [MAX_KEPT];
  logic [DIST_W-1:0]             kept_ins [MAX_KEPT];
  logic [KC_W-1:0]               kc_r, limit, kc_clamp, ins_pos;
  logic                          in_range_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [SQ_W-1:0]        sq_full;
  logic [SQ_W-1:0]               sq_r;
  logic [MAX_KEPT-1:0]           lt_r, lt_vec;
  logic                          eq_any_r, eq_any;
  logic                          full, do_ins;
  logic [KI_W-1:0]               idx_r;
  logic                          empty_rd_r, rd_last, out_load;
  logic signed [COORD_BITS-1:0]  coord_x;
  logic                          mem_we;
  logic                          out_valid_r, set_empty_r, last_result_r;
  logic [DIST_W-1:0]             distance_r;
  logic [RANK_W-1:0]             rank_r;

  assign coord_x = signed'(cur_r.coord[COORD_BITS-1:0]);
  assign eff_len = done_r ? '0 : qlen_r;
  assign mem_we  = (state_r == S_EXEC) && (cur_r.op == OP_QUERY) &&
                   (eff_len < LEN_W'(MAX_DIM));
  assign q_pop   = (state_r == S_IDLE) && !q_empty;

  assign sq_full = diff_r * diff_r;
  assign acc_sum = {1'b0, acc_r} + (DIST_W + 1)'(in_range_r ? sq_r : '0);
  assign acc_add = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];
  assign pos_inc = (pos_r <= LEN_W'(MAX_DIM)) ? pos_r + 1'b1 : pos_r;

  always_comb begin
    if (cfg_r == '0)                      limit = KC_W'(1);
    else if (32'(cfg_r) > 32'(MAX_KEPT))  limit = KC_W'(MAX_KEPT);
    else                                  limit = KC_W'(cfg_r);
    kc_clamp = (kc_r > limit) ? limit : kc_r;
  end

  always_comb begin
    eq_any = 1'b0;
    for (int i = 0; i < MAX_KEPT; i++) begin
      lt_vec[i] = (KC_W'(i) < kc_clamp) && (kept_r[i] < offer_r);
      if ((KC_W'(i) < kc_clamp) && (kept_r[i] == offer_r)) eq_any = 1'b1;
    end
  end

  assign ins_pos = KC_W'($countones(lt_r));
  assign full    = kc_r >= limit;
  assign do_ins  = !eq_any_r && !(full && ins_pos == kc_r);

  always_comb begin
    kept_ins[0] = lt_r[0] ? kept_r[0] : offer_r;
    for (int i = 1; i < MAX_KEPT; i++) begin
      if (lt_r[i])          kept_ins[i] = kept_r[i];
      else if (lt_r[i - 1]) kept_ins[i] = offer_r;
      else                  kept_ins[i] = kept_r[i - 1];
    end
  end

  assign rd_last  = empty_rd_r || (KC_W'(idx_r) + KC_W'(1) == kc_r);
  assign out_load = (state_r == S_READ) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (cur_r.op)
          OP_QUERY: state_nxt = S_IDLE;
          OP_POINT: state_nxt = done_r ? S_DIFF : S_IDLE;
          OP_READ:  state_nxt = S_READ;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ACC;
      S_ACC:  state_nxt = cur_r.last ? S_CMP : S_IDLE;
      S_CMP:  state_nxt = S_INS;
      S_INS:  state_nxt = S_IDLE;
      S_READ: if (out_load && rd_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(1);
      qlen_r      <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      done_r      <= 1'b0;
      kc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (state_r == S_EXEC && cur_r.op == OP_QUERY) begin
        if (done_r) begin
          pos_r <= '0;
          acc_r <= '0;
          kc_r  <= '0;
        end
        qlen_r <= (eff_len <= LEN_W'(MAX_DIM)) ? eff_len + 1'b1 : eff_len;
        done_r <= cur_r.last;
      end
      if (state_r == S_ACC) begin
        if (cur_r.last) begin
          acc_r <= '0;
          pos_r <= '0;
        end else begin
          acc_r <= acc_add;
          pos_r <= pos_inc;
        end
      end
      if (state_r == S_CMP) kc_r <= kc_clamp;
      if (state_r == S_INS && do_ins && !full) kc_r <= kc_r + 1'b1;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) cur_r <= q_head;
    if (mem_we) qmem[eff_len[AW-1:0]] <= coord_x;
    rd_data_r <= qmem[pos_r[AW-1:0]];
    if (state_r == S_DIFF) begin
      diff_r     <= DIFF_W'(coord_x) - DIFF_W'(rd_data_r);
      in_range_r <= (pos_r < LEN_W'(MAX_DIM)) && (pos_r < qlen_r);
    end
    if (state_r == S_SQ) sq_r <= unsigned'(sq_full);
    if (state_r == S_ACC) offer_r <= (pos_inc == qlen_r) ? acc_add : '0;
    if (state_r == S_CMP) begin
      lt_r     <= lt_vec;
      eq_any_r <= eq_any;
    end
    if (state_r == S_INS && do_ins) begin
      for (int i = 0; i < MAX_KEPT; i++) kept_r[i] <= kept_ins[i];
    end
    if (state_r == S_EXEC) begin
      idx_r      <= '0;
      empty_rd_r <= (kc_r == '0);
    end
    if (out_load) begin
      distance_r    <= empty_rd_r ? '0 : kept_r[idx_r];
      rank_r        <= empty_rd_r ? '0 : RANK_W'(idx_r);
      set_empty_r   <= empty_rd_r;
      last_result_r <= rd_last;
      idx_r         <= idx_r + 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_sq = distance_r;
  assign out_ch.rank        = rank_r;
  assign out_ch.set_empty   = set_empty_r;
  assign out_ch.last_result = last_result_r;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ndk_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_DIM = DEF_MAX_DIM;
  localparam int MAX_KEPT = DEF_MAX_KEPT;
  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_HOLD} rdy_mode_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] coord;
    logic               fin;
  } coord_txn_t;

  typedef struct {
    logic [DIST_W-1:0] dist_sq;
    logic [RANK_W-1:0] rank;
    logic              empty;
    logic              fin;
  } readout_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  ndk_in_if  in_ch ();
  ndk_out_if out_ch ();

  nearest_distance_keeper_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  coord_txn_t         coord_queue[$];
  readout_t           expected_readout[$];
  logic [COORD_W-1:0] cur_query[$];

  logic signed [COORD_W-1:0] q_coord [MAX_DIM];
  longint unsigned           kept_dist [MAX_KEPT];
  longint unsigned           acc = 0;
  int                        q_len = 0;
  int                        p_pos = 0;
  int                        kept_n = 0;
  int                        keep_cfg = 1;
  bit                        q_complete = 1'b0;

  int        errors = 0;
  int        n_txn = 0;
  int        n_results = 0;
  int        n_readouts = 0;
  int        n_cfg = 0;
  int        idle_cycles = 0;
  bit        in_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  rdy_mode_t stall_mode = RDY_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void offer_distance(longint unsigned d);
    int lim;
    int pos;
    lim = keep_cfg;
    if (lim == 0) lim = 1;
    if (lim > MAX_KEPT) lim = MAX_KEPT;
    if (kept_n > lim) kept_n = lim;
    for (int i = 0; i < kept_n; i++)
      if (kept_dist[i] == d) return;
    if (kept_n >= lim) begin
      if (d >= kept_dist[kept_n - 1]) return;
      kept_n--;
    end
    pos = 0;
    while (pos < kept_n && kept_dist[pos] < d) pos++;
    for (int i = kept_n; i > pos; i--) kept_dist[i] = kept_dist[i - 1];
    kept_dist[pos] = d;
    kept_n++;
  endfunction

  function automatic void track_transaction(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] coord,
                                            logic fin);
    longint          diff;
    longint unsigned sq;
    readout_t        r;
    case (cmd)
      CMD_QUERY: begin
        if (q_complete) begin
          q_complete = 1'b0;
          q_len = 0;
          p_pos = 0;
          acc = 0;
          kept_n = 0;
        end
        if (q_len < MAX_DIM) q_coord[q_len] = coord;
        if (q_len <= MAX_DIM) q_len++;
        if (fin) q_complete = 1'b1;
      end
      CMD_POINT: begin
        if (q_complete) begin
          if (p_pos < MAX_DIM && p_pos < q_len) begin
            diff = longint'($signed(coord)) - longint'(q_coord[p_pos]);
            sq = diff * diff;
            acc = (sq > DIST_MAX - acc) ? DIST_MAX : acc + sq;
          end
          if (p_pos <= MAX_DIM) p_pos++;
          if (fin) begin
            offer_distance((p_pos == q_len) ? acc : 64'd0);
            p_pos = 0;
            acc = 0;
          end
        end
      end
      CMD_READ: begin
        n_readouts++;
        if (kept_n == 0) begin
          r.dist_sq = '0;
          r.rank = '0;
          r.empty = 1'b1;
          r.fin = 1'b1;
          expected_readout = {expected_readout, r};
        end else begin
          for (int i = 0; i < kept_n; i++) begin
            r.dist_sq = DIST_W'(kept_dist[i]);
            r.rank = RANK_W'(i);
            r.empty = 1'b0;
            r.fin = (i == kept_n - 1);
            expected_readout = {expected_readout, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    readout_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        keep_cfg = cfg_wdata;
        n_cfg++;
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        track_transaction(in_ch.cmd, in_ch.coordinate, in_ch.last_coordinate);
        void'(coord_queue.pop_front());
        in_taken = 1'b1;
        n_txn++;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        n_results++;
        if (expected_readout.size() == 0) begin
          errors++;
          $error("unexpected result: distance_sq %0d rank %0d set_empty %0b last_result %0b",
                 out_ch.distance_sq, out_ch.rank, out_ch.set_empty, out_ch.last_result);
        end else begin
          want = expected_readout.pop_front();
          if (out_ch.distance_sq !== want.dist_sq) begin
            errors++;
            $error("distance_sq mismatch: expected %0d, got %0d", want.dist_sq,
                   out_ch.distance_sq);
          end
          if (out_ch.rank !== want.rank) begin
            errors++;
            $error("rank mismatch: expected %0d, got %0d", want.rank, out_ch.rank);
          end
          if (out_ch.set_empty !== want.empty) begin
            errors++;
            $error("set_empty mismatch: expected %0b, got %0b", want.empty, out_ch.set_empty);
          end
          if (out_ch.last_result !== want.fin) begin
            errors++;
            $error("last_result mismatch: expected %0b, got %0b", want.fin, out_ch.last_result);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (coord_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= coord_queue[0].cmd;
        in_ch.coordinate <= coord_queue[0].coord;
        in_ch.last_coordinate <= coord_queue[0].fin;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rdy_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == RDY_HOLD) ? $urandom_range(1, 25) : $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      RDY_OPEN:   out_ch.ready <= 1'b1;
      RDY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ch.ready <= ($urandom_range(0, 5) == 0);
      default:    out_ch.ready <= 1'b0;
    endcase
  end

  task automatic queue_coord(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] coord,
                             input logic fin);
    coord_txn_t t;
    t.cmd = cmd;
    t.coord = coord;
    t.fin = fin;
    coord_queue = {coord_queue, t};
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return COORD_W'($urandom_range(0, 16'hFFFF));
      default: return COORD_W'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  task automatic drain();
    while (coord_queue.size() != 0 || expected_readout.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_count(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic gen_random_part(input int budget);
    int                 made;
    int                 pick;
    int                 plen;
    int                 style;
    logic [COORD_W-1:0] c;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 || cur_query.size() == 0) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        cur_query.delete();
        for (int i = 0; i < plen; i++) begin
          c = rand_coord();
          cur_query = {cur_query, c};
          queue_coord(CMD_QUERY, c, i == plen - 1);
        end
        made += plen;
      end else if (pick < 72) begin
        plen = cur_query.size();
        if ($urandom_range(0, 7) == 0)
          plen = (plen > 1 && $urandom_range(0, 1) == 1) ? plen - 1 : plen + 1;
        style = $urandom_range(0, 3);
        for (int i = 0; i < plen; i++) begin
          if (i < cur_query.size() && style != 0)
            c = cur_query[i] + COORD_W'($urandom_range(0, 2 * style) - style);
          else
            c = rand_coord();
          queue_coord(CMD_POINT, c, i == plen - 1);
        end
        made += plen;
      end else if (pick < 86) begin
        queue_coord(CMD_READ, rand_coord(), 1'($urandom_range(0, 1)));
        made++;
      end else if (pick < 91) begin
        queue_coord(CMD_UNUSED, rand_coord(), 1'($urandom_range(0, 1)));
      end else begin
        // unfinished point: merges into the next point unless a new query starts first
        plen = $urandom_range(1, 3);
        for (int i = 0; i < plen; i++) queue_coord(CMD_POINT, rand_coord(), 1'b0);
        made += plen;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] plan [$];
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_QUERY;
    in_ch.coordinate = '0;
    in_ch.last_coordinate = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_coord(CMD_READ, 16'h0000, 1'b0);
    queue_coord(CMD_POINT, 16'h1234, 1'b1);
    queue_coord(CMD_UNUSED, 16'hFFFF, 1'b1);
    queue_coord(CMD_QUERY, 16'h7FFF, 1'b0);
    queue_coord(CMD_QUERY, 16'h8000, 1'b0);
    queue_coord(CMD_QUERY, 16'h0000, 1'b1);
    queue_coord(CMD_POINT, 16'h8000, 1'b0);
    queue_coord(CMD_POINT, 16'h7FFF, 1'b0);
    queue_coord(CMD_POINT, 16'hFFFF, 1'b1);
    queue_coord(CMD_READ, 16'hFFFF, 1'b1);
    queue_coord(CMD_POINT, 16'h0001, 1'b0);
    queue_coord(CMD_POINT, 16'h0002, 1'b1);
    queue_coord(CMD_READ, 16'h0000, 1'b0);
    queue_coord(CMD_POINT, 16'h7FFF, 1'b0);
    queue_coord(CMD_POINT, 16'h8000, 1'b0);
    queue_coord(CMD_POINT, 16'h0000, 1'b1);
    queue_coord(CMD_READ, 16'h0000, 1'b0);
    for (int i = 0; i < 4; i++) queue_coord(CMD_POINT, 16'h0003, i == 3);
    queue_coord(CMD_POINT, 16'h0005, 1'b0);
    queue_coord(CMD_QUERY, 16'h0003, 1'b1);
    queue_coord(CMD_READ, 16'h0000, 1'b0);
    queue_coord(CMD_POINT, 16'h0007, 1'b1);
    queue_coord(CMD_READ, 16'h0000, 1'b0);

    plan = '{5'd16, 5'd0, 5'd3, 5'd17, 5'd31, 5'd2, 5'd1, 5'd16, 5'd6, 5'd16};
    plan = {plan, CFG_W'($urandom_range(4, 15))};
    foreach (plan[p]) begin
      write_keep_count(plan[p]);
      gen_random_part(26);
      queue_coord(CMD_READ, 16'h0000, 1'b0);
    end
    drain();

    $display("Covered %0d input transactions, %0d readouts, %0d checked results",
             n_txn, n_readouts, n_results);
    $display("across %0d nearest_count writes, from 0 to 31", n_cfg);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
